[hdl/epr_pkg.sv]
package epr_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each (12 to 32).
    localparam int TRIG_ITERATIONS = 24;

    // Register stages from input acceptance to the result register.
    localparam int PIPE_LAT = TRIG_ITERATIONS + 8;
    // Side-band delay line feeding the point transform.
    localparam int SIDE_LEN = TRIG_ITERATIONS + 6;
    // Side-band tap seen by the matrix builder.
    localparam int ORDER_TAP = TRIG_ITERATIONS + 2;

    // Angle to turn-fraction scale factors, 2^48/360 and 2^48/(2*pi).
    localparam logic [47:0] DEG_TO_PHASE = 48'd781874935307;
    localparam logic [47:0] RAD_TO_PHASE = 48'h28BE60DB9391;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    localparam logic ORDER_XYZ = 1'b0;
    localparam logic ORDER_ZYX = 1'b1;

    typedef logic signed [31:0] t_trig;
    typedef logic signed [33:0] t_q;
    typedef logic [8:0][33:0]   t_mat;

    typedef struct packed {
        logic             zyx;
        logic [2:0][32:0] d;
        logic [2:0][31:0] piv;
    } t_side;

    function automatic logic signed [31:0] atan_val(input int unsigned idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q4.30 product rounded half up.
    function automatic t_q mul30(input t_q a, input t_q b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return $signed(p[63:30]);
    endfunction

endpackage

[hdl/euler_point_rotate_unit.sv]
// One stage per CORDIC step lies between an accepted input transaction and its result.
// Throughput: one transaction per cycle while the skid register is empty; the skid
// register lets the input keep flowing in the cycle in which the output stalls.
// Reset (synchronous, active low) clears all valid flags; the data path is not reset.
module euler_point_rotate_unit
    import epr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: angle_x, angle_y, angle_z, point_x, point_y, point_z,
    //        pivot_x, pivot_y, pivot_z (32 bits each, lowest first)
    input  logic [287:0] i_s_tdata,
    // tuser: rot_order, angle_unit, reverse_dir (lowest first)
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: out_x, out_y, out_z (32 bits each, lowest first)
    output logic [95:0]  o_m_tdata,
    // tuser: saturated
    output logic [0:0]   o_m_tuser
);

    // The whole pipeline advances together whenever the skid register is empty.
    // A result that reaches the last stage while the output is stalled is parked
    // in the skid register, which then freezes the pipeline until it drains.
    logic              w_en;
    logic              w_accept;
    logic [PIPE_LAT-1:0] r_vld;
    t_side             n_side;
    t_side             r_side [0:SIDE_LEN-1];
    logic [2:0][31:0]  w_phase;
    t_trig             w_cos [0:2];
    t_trig             w_sin [0:2];
    t_mat              w_mat;
    logic [31:0]       w_ox, w_oy, w_oz;
    logic              w_osat;
    logic              r_skid_vld;
    logic [96:0]       r_skid_data;
    logic [96:0]       w_pipe_data;

    assign w_en       = !r_skid_vld;
    assign o_s_tready = w_en;
    assign w_accept   = i_s_tvalid && w_en;

    // Valid flags follow the data down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_accept};
        end
    end

    // Side band: order flag, pivot-relative point and pivot, delayed to meet the
    // matrix builder and the point transform.
    always_comb begin
        n_side.zyx = i_s_tuser[0];
        for (int j = 0; j < 3; j++) begin
            n_side.piv[j] = i_s_tdata[192 + 32*j +: 32];
            n_side.d[j]   = 33'($signed(i_s_tdata[96 + 32*j +: 32]))
                          - 33'($signed(i_s_tdata[192 + 32*j +: 32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // One phase converter and one CORDIC pipeline per Euler angle.
    for (genvar a = 0; a < 3; a++) begin : g_angle
        epr_phase u_phase (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (i_s_tdata[32*a +: 32]),
            .i_rad   (i_s_tuser[1]),
            .i_rev   (i_s_tuser[2]),
            .o_phase (w_phase[a])
        );
        epr_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_phase[a]),
            .o_cos   (w_cos[a]),
            .o_sin   (w_sin[a])
        );
    end

    epr_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cx  (w_cos[0]),
        .i_sx  (w_sin[0]),
        .i_cy  (w_cos[1]),
        .i_sy  (w_sin[1]),
        .i_cz  (w_cos[2]),
        .i_sz  (w_sin[2]),
        .i_zyx (r_side[ORDER_TAP].zyx),
        .o_mat (w_mat)
    );

    epr_xform u_xform (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_mat  (w_mat),
        .i_side (r_side[SIDE_LEN-1]),
        .o_x    (w_ox),
        .o_y    (w_oy),
        .o_z    (w_oz),
        .o_sat  (w_osat)
    );

    assign w_pipe_data = {w_osat, w_oz, w_oy, w_ox};

    // Output skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[PIPE_LAT-1] && !i_m_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= w_pipe_data;
        end
    end

    assign o_m_tvalid = r_skid_vld || r_vld[PIPE_LAT-1];
    assign o_m_tdata  = r_skid_vld ? r_skid_data[95:0] : w_pipe_data[95:0];
    assign o_m_tuser  = r_skid_vld ? r_skid_data[96]   : w_pipe_data[96];

    // A stalled pipeline result must be captured by the skid register.
    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_vld && r_vld[PIPE_LAT-1] && !i_m_tready) |=> r_skid_vld)
        else $error("stalled result not captured");

    // A parked result keeps its value until it is taken.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_m_tready) |=> (r_skid_vld && $stable(r_skid_data)))
        else $error("parked result lost or changed");

    // The skid register only fills from a stalled pipeline result.
    a_skid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_vld[PIPE_LAT-1] && !i_m_tready))
        else $error("skid register filled without a stalled result");

endmodule

[hdl/epr_phase.sv]
module epr_phase
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    input  logic        i_rad,
    input  logic        i_rev,
    output logic [31:0] o_phase
);

    logic signed [32:0] w_a;
    logic [47:0]        w_k;
    logic signed [57:0] n_ph, n_pl;
    logic signed [57:0] r_ph, r_pl;
    logic signed [63:0] w_sum;
    logic [31:0]        r_phase;

    always_comb begin
        w_a  = i_rev ? -33'($signed(i_angle)) : 33'($signed(i_angle));
        w_k  = i_rad ? RAD_TO_PHASE : DEG_TO_PHASE;
        n_ph = w_a * $signed({1'b0, w_k[47:24]});
        n_pl = w_a * $signed({1'b0, w_k[23:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= n_ph;
            r_pl <= n_pl;
        end
    end

    assign w_sum = (64'(r_ph) <<< 24) + 64'(r_pl) + 64'sh80000000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= w_sum[63:32];
        end
    end

    assign o_phase = r_phase;

endmodule

[hdl/epr_cordic.sv]
module epr_cordic
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_phase,
    output t_trig       o_cos,
    output t_trig       o_sin
);

    localparam int N = TRIG_ITERATIONS;

    logic [31:0]        w_p;
    logic signed [31:0] w_z0;
    logic signed [33:0] r_x [0:N-1];
    logic signed [33:0] r_y [0:N-1];
    logic signed [31:0] r_z [0:N-1];
    logic [1:0]         r_q [0:N-1];
    t_trig              r_cos, r_sin;

    assign w_p  = i_phase + 32'h20000000;
    assign w_z0 = $signed({2'b00, w_p[29:0]}) - 32'sh20000000;

    for (genvar g = 0; g < N; g++) begin : g_iter
        logic signed [33:0] w_xi, w_yi;
        logic signed [31:0] w_zi;
        logic [1:0]         w_qi;
        if (g == 0) begin : g_first
            assign w_xi = CORDIC_GAIN;
            assign w_yi = '0;
            assign w_zi = w_z0;
            assign w_qi = w_p[31:30];
        end else begin : g_next
            assign w_xi = r_x[g-1];
            assign w_yi = r_y[g-1];
            assign w_zi = r_z[g-1];
            assign w_qi = r_q[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_zi >= 0) begin
                    r_x[g] <= w_xi - (w_yi >>> g);
                    r_y[g] <= w_yi + (w_xi >>> g);
                    r_z[g] <= w_zi - atan_val(g);
                end else begin
                    r_x[g] <= w_xi + (w_yi >>> g);
                    r_y[g] <= w_yi - (w_xi >>> g);
                    r_z[g] <= w_zi + atan_val(g);
                end
                r_q[g] <= w_qi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[N-1])
                2'd0: begin
                    r_cos <= t_trig'(r_x[N-1]);
                    r_sin <= t_trig'(r_y[N-1]);
                end
                2'd1: begin
                    r_cos <= t_trig'(-r_y[N-1]);
                    r_sin <= t_trig'(r_x[N-1]);
                end
                2'd2: begin
                    r_cos <= t_trig'(-r_x[N-1]);
                    r_sin <= t_trig'(-r_y[N-1]);
                end
                default: begin
                    r_cos <= t_trig'(r_y[N-1]);
                    r_sin <= t_trig'(-r_x[N-1]);
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[hdl/epr_matrix.sv]
module epr_matrix
    import epr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_trig i_cx,
    input  t_trig i_sx,
    input  t_trig i_cy,
    input  t_trig i_sy,
    input  t_trig i_cz,
    input  t_trig i_sz,
    input  logic  i_zyx,
    output t_mat  o_mat
);

    t_q w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    // First level of products.
    t_q r_p1_cycz, r_p1_cxcy, r_p1_cysz, r_p1_sxcy;
    t_q r_p1_cxsz, r_p1_cxcz, r_p1_sxsz, r_p1_sxcz;
    t_q r_p1_v6, r_p1_v7, r_p1_sy, r_p1_cz, r_p1_sz;
    logic r_p1_zyx;
    // Second level.
    t_q r_p2_cycz, r_p2_cxcy, r_p2_cysz, r_p2_sxcy;
    t_q r_p2_cxsz, r_p2_cxcz, r_p2_sxsz, r_p2_sxcz;
    t_q r_p2_v7cz, r_p2_v7sz, r_p2_v6cz, r_p2_v6sz, r_p2_sy;
    logic r_p2_zyx;
    t_mat n_mat, r_mat;

    assign w_cx = t_q'(i_cx);
    assign w_sx = t_q'(i_sx);
    assign w_cy = t_q'(i_cy);
    assign w_sy = t_q'(i_sy);
    assign w_cz = t_q'(i_cz);
    assign w_sz = t_q'(i_sz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_cycz <= mul30(w_cy, w_cz);
            r_p1_cxcy <= mul30(w_cx, w_cy);
            r_p1_cysz <= mul30(w_cy, w_sz);
            r_p1_sxcy <= mul30(w_sx, w_cy);
            r_p1_cxsz <= mul30(w_cx, w_sz);
            r_p1_cxcz <= mul30(w_cx, w_cz);
            r_p1_sxsz <= mul30(w_sx, w_sz);
            r_p1_sxcz <= mul30(w_sx, w_cz);
            r_p1_v6   <= mul30(w_cx, w_sy);
            r_p1_v7   <= mul30(w_sx, w_sy);
            r_p1_sy   <= w_sy;
            r_p1_cz   <= w_cz;
            r_p1_sz   <= w_sz;
            r_p1_zyx  <= i_zyx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_cycz <= r_p1_cycz;
            r_p2_cxcy <= r_p1_cxcy;
            r_p2_cysz <= r_p1_cysz;
            r_p2_sxcy <= r_p1_sxcy;
            r_p2_cxsz <= r_p1_cxsz;
            r_p2_cxcz <= r_p1_cxcz;
            r_p2_sxsz <= r_p1_sxsz;
            r_p2_sxcz <= r_p1_sxcz;
            r_p2_v7cz <= mul30(r_p1_v7, r_p1_cz);
            r_p2_v7sz <= mul30(r_p1_v7, r_p1_sz);
            r_p2_v6cz <= mul30(r_p1_v6, r_p1_cz);
            r_p2_v6sz <= mul30(r_p1_v6, r_p1_sz);
            r_p2_sy   <= r_p1_sy;
            r_p2_zyx  <= r_p1_zyx;
        end
    end

    always_comb begin
        n_mat[0] = r_p2_cycz;
        n_mat[8] = r_p2_cxcy;
        if (r_p2_zyx == ORDER_XYZ) begin
            n_mat[1] = -r_p2_cysz;
            n_mat[2] = r_p2_sy;
            n_mat[3] = r_p2_v7cz + r_p2_cxsz;
            n_mat[4] = r_p2_cxcz - r_p2_v7sz;
            n_mat[5] = -r_p2_sxcy;
            n_mat[6] = r_p2_sxsz - r_p2_v6cz;
            n_mat[7] = r_p2_v6sz + r_p2_sxcz;
        end else begin
            n_mat[1] = r_p2_v7cz - r_p2_cxsz;
            n_mat[2] = r_p2_sxsz + r_p2_v6cz;
            n_mat[3] = r_p2_cysz;
            n_mat[4] = r_p2_cxcz + r_p2_v7sz;
            n_mat[5] = r_p2_v6sz - r_p2_sxcz;
            n_mat[6] = -r_p2_sy;
            n_mat[7] = r_p2_sxcy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

endmodule

[hdl/epr_xform.sv]
module epr_xform
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_mat        i_mat,
    input  t_side       i_side,
    output logic [31:0] o_x,
    output logic [31:0] o_y,
    output logic [31:0] o_z,
    output logic        o_sat
);

    logic signed [66:0] w_prod [0:8];
    logic signed [64:0] r_t [0:8];
    logic [2:0][31:0]   r_piv;
    logic signed [66:0] w_sum [0:2];
    logic signed [39:0] w_v [0:2];
    logic [2:0][31:0]   n_out;
    logic [2:0]         n_sat;
    logic [2:0][31:0]   r_out;
    logic               r_sat;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_prod[k] = $signed(i_side.d[k % 3]) * $signed(i_mat[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_t[k] <= w_prod[k][66:2];
            end
            r_piv <= i_side.piv;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 67'(r_t[3*r]) + 67'(r_t[3*r+1]) + 67'(r_t[3*r+2])
                     + 67'sd134217728;
            w_v[r]   = 40'($signed(w_sum[r][66:28])) + 40'($signed(r_piv[r]));
            if (w_v[r] > 40'sd2147483647) begin
                n_out[r] = 32'h7FFFFFFF;
                n_sat[r] = 1'b1;
            end else if (w_v[r] < -40'sd2147483648) begin
                n_out[r] = 32'h80000000;
                n_sat[r] = 1'b1;
            end else begin
                n_out[r] = w_v[r][31:0];
                n_sat[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
            r_sat <= |n_sat;
        end
    end

    assign o_x   = r_out[0];
    assign o_y   = r_out[1];
    assign o_z   = r_out[2];
    assign o_sat = r_sat;

endmodule
